>>> sv/ordered_id_list_engine_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered id list engine
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ID_LIST_ENGINE_MACROS_SVH
`define ORDERED_ID_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define OILE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ordered id list engine: check failed");

// next-cycle implication
`define OILE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ordered id list engine: check failed");

`else

`define OILE_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define OILE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> sv/oile_pkg.sv
// ----------------------------------------------------------------------------
// oile_pkg
// Shared types and constants of the ordered id list engine.
// ----------------------------------------------------------------------------
package oile_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int ID_W             = 32;
    localparam int KIND_W           = 4;
    localparam int POS_W            = 4;
    localparam int CNT_W            = 5;

    typedef enum logic [KIND_W-1:0] {
        REQ_ADD_HEAD  = 4'd0,
        REQ_ADD_TAIL  = 4'd1,
        REQ_RM_HEAD   = 4'd2,
        REQ_RM_TAIL   = 4'd3,
        REQ_RM_ID     = 4'd4,
        REQ_FIND      = 4'd5,
        REQ_PEEK_HEAD = 4'd6,
        REQ_PEEK_TAIL = 4'd7,
        REQ_CLEAR     = 4'd8
    } req_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_SHIFT,
        ST_RESP
    } seq_state_t;

    typedef struct packed {
        logic             ok;
        logic [ID_W-1:0]  result_id;
        logic [POS_W-1:0] match_position;
        logic [CNT_W-1:0] entry_count;
    } result_t;

endpackage

>>> sv/oile_ram.sv
// ----------------------------------------------------------------------------
// oile_ram
// Generic one-write, one-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module oile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/oile_seq.sv
// ----------------------------------------------------------------------------
// oile_seq
// Request sequencer: keeps head pointer and length of the circular store,
// drives the RAM and walks it for search and compaction.
// ----------------------------------------------------------------------------
module oile_seq
    import oile_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request side
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [KIND_W-1:0]           req_kind,
    input  logic [ID_W-1:0]             req_id,
    // result side
    output logic                        res_valid,
    input  logic                        res_ready,
    output result_t                     res,
    // RAM port
    output logic                        ram_wr_en,
    output logic [$clog2(CAPACITY)-1:0] ram_wr_addr,
    output logic [ID_W-1:0]             ram_wr_data,
    output logic [$clog2(CAPACITY)-1:0] ram_rd_addr,
    input  logic [ID_W-1:0]             ram_rd_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = AW + 2;
    localparam logic [AW:0]   CAP_S   = (AW+1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_P  = AW'(CAPACITY - 1);
    localparam logic [LW-1:0] CAP_L   = LW'(CAPACITY);

    seq_state_t      state_reg, state_next;
    req_kind_t       kind_reg, kind_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [LW-1:0]   len_reg, len_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic            ok_reg, ok_next;
    logic [ID_W-1:0] rid_reg, rid_next;
    logic [AW-1:0]   pos_reg, pos_next;

    logic            accept;
    req_kind_t       in_kind;
    logic            has_room;
    logic            non_empty;
    logic            hit;
    logic            more_scan;
    logic            more_shift;
    logic [AW-1:0]   head_dec;
    logic [AW-1:0]   head_inc;
    logic [AW-1:0]   tail_idx;

    // map a position from the head onto a RAM address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] l);
        logic [AW:0] s;
        begin
            s = {1'b0, head} + {1'b0, l};
            if (s >= CAP_S) begin
                s = s - CAP_S;
            end
            return s[AW-1:0];
        end
    endfunction

    assign accept     = req_valid && req_ready;
    assign in_kind    = req_kind_t'(req_kind);
    assign has_room   = (len_reg < CAP_L);
    assign non_empty  = (len_reg != '0);
    assign hit        = (ram_rd_data == id_reg);
    assign more_scan  = ((CW'(idx_reg) + CW'(1)) < CW'(len_reg));
    assign more_shift = ((CW'(idx_reg) + CW'(2)) < CW'(len_reg));
    assign head_dec   = (head_reg == '0) ? LAST_P : head_reg - AW'(1);
    assign head_inc   = (head_reg == LAST_P) ? '0 : head_reg + AW'(1);
    assign tail_idx   = AW'(len_reg - LW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        id_reg   <= id_next;
        idx_reg  <= idx_next;
        ok_reg   <= ok_next;
        rid_reg  <= rid_next;
        pos_reg  <= pos_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_kind)
                        REQ_RM_HEAD, REQ_RM_TAIL, REQ_PEEK_HEAD, REQ_PEEK_TAIL: begin
                            state_next = non_empty ? ST_READ : ST_RESP;
                        end
                        REQ_RM_ID, REQ_FIND: begin
                            state_next = non_empty ? ST_SCAN : ST_RESP;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_RESP;
            end
            ST_SCAN: begin
                if (hit) begin
                    state_next = (kind_reg == REQ_RM_ID && more_scan) ? ST_SHIFT : ST_RESP;
                end else if (!more_scan) begin
                    state_next = ST_RESP;
                end
            end
            ST_SHIFT: begin
                if (!more_shift) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb begin
        kind_next   = kind_reg;
        id_next     = id_reg;
        head_next   = head_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        ok_next     = ok_reg;
        rid_next    = rid_reg;
        pos_next    = pos_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = head_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_addr = head_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next = in_kind;
                    id_next   = req_id;
                    ok_next   = 1'b0;
                    rid_next  = '0;
                    pos_next  = '0;
                    idx_next  = '0;
                    case (in_kind)
                        REQ_ADD_HEAD: begin
                            if (has_room) begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = head_dec;
                                ram_wr_data = req_id;
                                head_next   = head_dec;
                                len_next    = len_reg + LW'(1);
                                ok_next     = 1'b1;
                                rid_next    = req_id;
                            end
                        end
                        REQ_ADD_TAIL: begin
                            if (has_room) begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = phys(head_reg, AW'(len_reg));
                                ram_wr_data = req_id;
                                pos_next    = AW'(len_reg);
                                len_next    = len_reg + LW'(1);
                                ok_next     = 1'b1;
                                rid_next    = req_id;
                            end
                        end
                        REQ_RM_TAIL, REQ_PEEK_TAIL: begin
                            idx_next    = tail_idx;
                            ram_rd_addr = phys(head_reg, tail_idx);
                        end
                        REQ_CLEAR: begin
                            len_next = '0;
                            ok_next  = 1'b1;
                        end
                        default: begin
                            // head-side reads and searches start at the head address
                            ram_rd_addr = head_reg;
                        end
                    endcase
                end
            end
            ST_READ: begin
                ok_next  = 1'b1;
                rid_next = ram_rd_data;
                pos_next = idx_reg;
                if (kind_reg == REQ_RM_HEAD) begin
                    head_next = head_inc;
                    len_next  = len_reg - LW'(1);
                end else if (kind_reg == REQ_RM_TAIL) begin
                    len_next  = len_reg - LW'(1);
                end
            end
            ST_SCAN: begin
                ram_rd_addr = phys(head_reg, idx_reg + AW'(1));
                if (hit) begin
                    ok_next  = 1'b1;
                    rid_next = ram_rd_data;
                    pos_next = idx_reg;
                    if (kind_reg == REQ_RM_ID && !more_scan) begin
                        len_next = len_reg - LW'(1);
                    end
                end else if (more_scan) begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_SHIFT: begin
                // move entry idx+1 down to idx, fetch the one after it
                ram_wr_en   = 1'b1;
                ram_wr_addr = phys(head_reg, idx_reg);
                ram_wr_data = ram_rd_data;
                ram_rd_addr = phys(head_reg, idx_reg + AW'(2));
                if (more_shift) begin
                    idx_next = idx_reg + AW'(1);
                end else begin
                    len_next = len_reg - LW'(1);
                end
            end
            default: begin
                ram_rd_addr = head_reg;
            end
        endcase
    end

    // outputs
    always_comb begin
        req_ready          = (state_reg == ST_IDLE);
        res_valid          = (state_reg == ST_RESP);
        res.ok             = ok_reg;
        res.result_id      = rid_reg;
        res.match_position = POS_W'(pos_reg);
        res.entry_count    = CNT_W'(len_reg);
    end

endmodule

>>> sv/ordered_id_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_id_list_engine
// Ordered list of signed 32-bit ids with add, remove, find, peek and clear.
// ----------------------------------------------------------------------------
// The list lives in one RAM of CAPACITY words used as a ring: a head pointer
// and a length register give the order, so adds and removes at either end
// touch one word. One request is handled at a time. Adds, clear and unknown
// kinds go from acceptance straight to the result state; peeks and end
// removals first pass a read state for the registered RAM data, unless the
// list is empty. Find and remove by id walk the list one entry per cycle
// through the single read port and stop at the first hit; remove by id then
// moves every later entry one place toward the head, one per cycle. The
// result sits in an output register, so the next request is accepted while
// it waits to be taken.
`include "ordered_id_list_engine_macros.svh"

module ordered_id_list_engine
    import oile_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] item_id
    input  logic [3:0]  s_tuser,   // [3:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] result_id, [35:32] match_position,
                                   // [40:36] entry_count, [47:41] zero
    output logic [0:0]  m_tuser    // [0] ok
);

    localparam int AW = $clog2(CAPACITY);

    logic            res_valid;
    logic            res_ready;
    result_t         res;
    logic            ram_wr_en;
    logic [AW-1:0]   ram_wr_addr;
    logic [ID_W-1:0] ram_wr_data;
    logic [AW-1:0]   ram_rd_addr;
    logic [ID_W-1:0] ram_rd_data;

    logic            m_tvalid_reg, m_tvalid_next;
    result_t         out_reg, out_next;

    oile_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_kind    (s_tuser),
        .req_id      (s_tdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    oile_ram #(
        .WIDTH (ID_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // load the output register whenever it is empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_reg.entry_count, out_reg.match_position, out_reg.result_id};
    assign m_tuser  = out_reg.ok;

    `OILE_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `OILE_ASSERT_NEXT(a_result_lands, aclk, aresetn, res_valid && res_ready, m_tvalid)
    `OILE_ASSERT_NOW(a_fail_zero_fields, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[35:0] == 36'd0)

endmodule

>>> test/tb_ordered_id_list_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_id_list_engine
// Self-checking bench for the ordered id list engine. A tracker keeps its own
// copy of the id list and predicts every result. It checks each returned
// result against the oldest prediction. Requests come first as a directed
// sweep of edge cases, then as random traffic in fill, drain and mixed phases.
// Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb_ordered_id_list_engine;
    import oile_pkg::*;

    localparam int              CAPACITY      = DEFAULT_CAPACITY;
    localparam int              RANDOM_ITEMS  = 1700;
    localparam int              ID_POOL_N     = 6;
    localparam logic [KIND_W-1:0] REQ_BAD_LO  = 4'd9;
    localparam logic [KIND_W-1:0] REQ_BAD_HI  = 4'd15;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    // ------------------------------------------------------------------------
    // Tracker: shadow list plus queue of predicted results
    // ------------------------------------------------------------------------
    class id_list_tracker;
        logic [ID_W-1:0] entries [CAPACITY];
        int              length;
        result_t         expected_results [$];
        int unsigned     mismatches;

        function new();
            length     = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id);
            result_t exp;
            int      i;
            int      hit;
            exp = '0;
            hit = -1;
            for (i = 0; i < length; i++)
                if (hit < 0 && entries[i] == id)
                    hit = i;
            case (kind)
                REQ_ADD_HEAD: begin
                    if (length < CAPACITY) begin
                        for (i = length; i > 0; i--)
                            entries[i] = entries[i-1];
                        entries[0] = id;
                        length++;
                        exp.ok        = 1'b1;
                        exp.result_id = id;
                    end
                end
                REQ_ADD_TAIL: begin
                    if (length < CAPACITY) begin
                        entries[length]    = id;
                        exp.match_position = length[POS_W-1:0];
                        length++;
                        exp.ok        = 1'b1;
                        exp.result_id = id;
                    end
                end
                REQ_RM_HEAD, REQ_PEEK_HEAD: begin
                    if (length > 0) begin
                        exp.ok        = 1'b1;
                        exp.result_id = entries[0];
                        if (kind == REQ_RM_HEAD) begin
                            for (i = 0; i + 1 < length; i++)
                                entries[i] = entries[i+1];
                            length--;
                        end
                    end
                end
                REQ_RM_TAIL, REQ_PEEK_TAIL: begin
                    if (length > 0) begin
                        exp.ok             = 1'b1;
                        exp.result_id      = entries[length-1];
                        exp.match_position = POS_W'(length - 1);
                        if (kind == REQ_RM_TAIL)
                            length--;
                    end
                end
                REQ_RM_ID, REQ_FIND: begin
                    if (hit >= 0) begin
                        exp.ok             = 1'b1;
                        exp.result_id      = entries[hit];
                        exp.match_position = hit[POS_W-1:0];
                        if (kind == REQ_RM_ID) begin
                            for (i = hit; i + 1 < length; i++)
                                entries[i] = entries[i+1];
                            length--;
                        end
                    end
                end
                REQ_CLEAR: begin
                    length = 0;
                    exp.ok = 1'b1;
                end
                default: ;  // unknown kind: no change, zero fields but the entry count
            endcase
            exp.entry_count = length[CNT_W-1:0];
            expected_results.push_back(exp);
        endfunction

        function void check_result(logic ok, logic [ID_W-1:0] rid,
                                   logic [POS_W-1:0] pos, logic [CNT_W-1:0] cnt);
            result_t exp;
            if (expected_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result ok=%0b id=%h pos=%0d cnt=%0d",
                                        ok, rid, pos, cnt));
                return;
            end
            exp = expected_results.pop_front();
            if (ok !== exp.ok || rid !== exp.result_id ||
                pos !== exp.match_position || cnt !== exp.entry_count)
                note_mismatch($sformatf(
                    "exp ok=%0b id=%h pos=%0d cnt=%0d / got ok=%0b id=%h pos=%0d cnt=%0d",
                    exp.ok, exp.result_id, exp.match_position, exp.entry_count,
                    ok, rid, pos, cnt));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [ID_W-1:0]   s_tdata  = '0;
    logic [KIND_W-1:0] s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [47:0]       m_tdata;
    logic [0:0]        m_tuser;

    id_list_tracker tracker = new();
    int unsigned    accepted_requests = 0;
    logic [ID_W-1:0] id_pool [ID_POOL_N];

    always #10 aclk = ~aclk;

    ordered_id_list_engine #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Sample both handshakes at the edge; requests are noted before results.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tracker.note_request(s_tuser, s_tdata);
                accepted_requests++;
            end
            if (m_tvalid && m_tready)
                tracker.check_result(m_tuser[0], m_tdata[31:0], m_tdata[35:32],
                                     m_tdata[40:36]);
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= id;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_requests(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(4) == 0)
            return $urandom();
        return id_pool[$urandom_range(ID_POOL_N-1)];
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(input int mode);
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return KIND_W'($urandom_range(REQ_BAD_HI, REQ_BAD_LO));
        if (r < 4 && mode == MODE_MIXED)
            return REQ_CLEAR;
        case (mode)
            MODE_FILL:
                if (r < 64)
                    return ($urandom_range(1) != 0) ? REQ_ADD_TAIL : REQ_ADD_HEAD;
                else
                    return KIND_W'($urandom_range(REQ_PEEK_TAIL, REQ_RM_HEAD));
            MODE_DRAIN:
                if (r < 64)
                    return KIND_W'($urandom_range(REQ_RM_ID, REQ_RM_HEAD));
                else if (r < 76)
                    return ($urandom_range(1) != 0) ? REQ_ADD_TAIL : REQ_ADD_HEAD;
                else
                    return KIND_W'($urandom_range(REQ_PEEK_TAIL, REQ_FIND));
            default:
                return KIND_W'($urandom_range(REQ_PEEK_TAIL, REQ_ADD_HEAD));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: own stall pattern, plus one long hold-off under load
    // ------------------------------------------------------------------------
    initial begin
        int  stall_mode;
        int  span;
        bit  hold_done;
        hold_done = 1'b0;
        wait (aresetn);
        forever begin
            stall_mode = $urandom_range(2);
            span       = $urandom_range(256, 64);
            repeat (span) begin
                @(posedge aclk);
                if (!hold_done && accepted_requests >= 500) begin
                    // starve the output so the engine backs up into its input
                    m_tready <= 1'b0;
                    repeat (400) @(posedge aclk);
                    hold_done = 1'b1;
                end else begin
                    case (stall_mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= ($urandom_range(3) != 0);
                        default: m_tready <= ($urandom_range(3) == 0);
                    endcase
                end
            end
        end
    end

    initial begin
        #(10_000_000);
        $display("** ordered_id_list_engine: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [KIND_W-1:0] kind;
        int                sent;
        int                burst_left;
        int                gap;
        int                mode;
        int                segment_left;
        bit                paused;

        id_pool[0] = 32'h8000_0000;
        id_pool[1] = 32'h7FFF_FFFF;
        id_pool[2] = 32'h0000_0000;
        id_pool[3] = 32'hFFFF_FFFF;
        id_pool[4] = $urandom();
        id_pool[5] = $urandom();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list: every remove, find and peek fails
        send_request(REQ_RM_HEAD,   32'h0000_0000);
        send_request(REQ_RM_TAIL,   32'h0000_0000);
        send_request(REQ_RM_ID,     32'h0000_0000);
        send_request(REQ_FIND,      32'h0000_0000);
        send_request(REQ_PEEK_HEAD, 32'h0000_0000);
        send_request(REQ_PEEK_TAIL, 32'h0000_0000);
        send_request(REQ_BAD_LO,    32'hFFFF_FFFF);
        // extremes, duplicates, first-match lookups and misses
        send_request(REQ_ADD_HEAD,  32'h8000_0000);
        send_request(REQ_ADD_TAIL,  32'h7FFF_FFFF);
        send_request(REQ_ADD_HEAD,  32'h0000_0000);
        send_request(REQ_ADD_TAIL,  32'h8000_0000);
        send_request(REQ_FIND,      32'h8000_0000);
        send_request(REQ_FIND,      32'h1234_5678);
        send_request(REQ_PEEK_HEAD, 32'hFFFF_FFFF);
        send_request(REQ_PEEK_TAIL, 32'hFFFF_FFFF);
        send_request(REQ_RM_ID,     32'h8000_0000);
        send_request(REQ_RM_ID,     32'h5555_AAAA);
        send_request(REQ_RM_TAIL,   32'h0000_0000);
        send_request(REQ_RM_HEAD,   32'h0000_0000);
        send_request(REQ_BAD_HI,    32'h0000_0000);
        send_request(REQ_ADD_TAIL,  32'hFFFF_FFFF);
        send_request(REQ_CLEAR,     32'hFFFF_FFFF);
        send_request(REQ_PEEK_HEAD, 32'h0000_0000);

        sent         = 0;
        burst_left   = 1;
        mode         = MODE_FILL;
        segment_left = $urandom_range(80, 30);
        paused       = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (segment_left == 0) begin
                mode         = $urandom_range(MODE_MIXED);
                segment_left = $urandom_range(80, 30);
            end
            if ($urandom_range(63) == 0)
                id_pool[$urandom_range(ID_POOL_N-1, 4)] = $urandom();
            kind = pick_kind(mode);
            send_request(kind, pick_id());
            segment_left--;
            if (kind <= REQ_CLEAR)
                sent++;
            if (!paused && sent >= 1100) begin
                // let the engine drain completely before carrying on
                paused = 1'b1;
                s_tvalid <= 1'b0;
                while (tracker.pending() != 0) @(posedge aclk);
                @(posedge aclk);
            end else if (--burst_left == 0) begin
                burst_left = $urandom_range(24, 1);
                gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
                if (gap != 0)
                    idle_requests(gap);
            end
        end
        s_tvalid <= 1'b0;

        while (tracker.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (tracker.mismatches == 0)
            $display("** ordered_id_list_engine: PASSED **");
        else
            $display("** ordered_id_list_engine: FAILED **");
        $finish;
    end

endmodule
